// ===== rtl/rraa_pkg.sv =====
// shared types, constants and width helpers for the ring resource age arbiter
package rraa_pkg;

  localparam int MAX_USERS_DEF = 8;
  localparam int NU_W          = 4;
  localparam int USER_W        = 3;
  localparam int KIND_W        = 2;
  localparam int TIME_W        = 32;
  localparam int DATA_W        = 8;
  localparam int QDEPTH        = 2;
  localparam int QPTR_W        = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W        = $clog2(QDEPTH + 1);

  localparam logic [NU_W-1:0] NUM_USERS_RST = 4'd5;

  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_REQ  = 2'd1;
  localparam logic [1:0] OP_REL  = 2'd2;

  typedef enum logic [KIND_W-1:0] {
    KIND_NONE  = 2'd0,
    KIND_GRANT = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    CMD_TICK,
    CMD_REQ,
    CMD_REL,
    CMD_ERR
  } cmd_cls_t;

  typedef struct packed {
    cmd_cls_t            cls;
    logic [USER_W-1:0]   user;
  } cmd_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_READ,
    B_EVAL,
    B_EMIT,
    B_EMIT2
  } back_state_t;

  // width of the ring size, wide enough for the config field too
  function automatic int size_w(input int m);
    int w;
    w = $clog2(m + 1);
    return (w > NU_W) ? w : NU_W;
  endfunction

  function automatic int idx_w(input int m);
    return (m > 1) ? $clog2(m) : 1;
  endfunction

endpackage

// ===== rtl/ring_resource_age_arbiter_unit.sv =====
// top level of the ring resource age arbiter
//
// s_axis carries commands: tick of time, request or release by one user.
// m_axis carries results: accepted, grant or error, with tlast on the final
// result of each command. A release that frees both neighbours gives two
// grant results, left neighbour first.
// cfg_we/cfg_wdata set num_users; write it only while no command is in flight.
// A two-entry command queue sits between the input and the execution
// sequencer, so input transfers keep being taken while a result is stalled.
// A tick or an error gives its result straight from the idle state; a request
// is read, evaluated and emitted, and a release reads and evaluates once per neighbour.
// The sequencer takes a new command every cycle for ticks and errors while the
// result register is free, and takes none while a request or release is in
// progress: each neighbour test reads three stamps through the single
// read port of the stamp ram, one per cycle.
// Reset empties the queue, drops any pending result, clears every user to
// thinking with a zero stamp, zeroes the time counter and sets num_users to 5.
// A receiver stall holds the result and, once the queue fills, s_axis_tready.
module ring_resource_age_arbiter_unit #(
  parameter int MAX_USERS = rraa_pkg::MAX_USERS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [rraa_pkg::NU_W-1:0]   cfg_wdata,       // num_users
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [rraa_pkg::DATA_W-1:0] s_axis_tdata,    // opcode[1:0], user[4:2]
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [rraa_pkg::DATA_W-1:0] m_axis_tdata,    // kind[1:0], granted_user[4:2]
  output logic                        m_axis_tlast
);
  import rraa_pkg::*;

  localparam int SZ_W = size_w(MAX_USERS);

  logic [NU_W-1:0]   num_users;
  logic [SZ_W-1:0]   ring_n;
  cmd_t              cmd;
  logic              cmd_valid;
  logic              cmd_pop;
  kind_t             out_kind;
  logic [USER_W-1:0] out_user;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_users <= NUM_USERS_RST;
    end else if (cfg_we) begin
      num_users <= cfg_wdata;
    end
  end

  always_comb begin
    if (num_users == '0) begin
      ring_n = SZ_W'(1);
    end else if (SZ_W'(num_users) > SZ_W'(MAX_USERS)) begin
      ring_n = SZ_W'(MAX_USERS);
    end else begin
      ring_n = SZ_W'(num_users);
    end
  end

  rraa_front #(
    .MAX_USERS(MAX_USERS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .ring_n       (ring_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .cmd          (cmd),
    .cmd_valid    (cmd_valid),
    .cmd_pop      (cmd_pop)
  );

  rraa_back #(
    .MAX_USERS(MAX_USERS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .ring_n   (ring_n),
    .cmd      (cmd),
    .cmd_valid(cmd_valid),
    .cmd_pop  (cmd_pop),
    .out_ready(m_axis_tready),
    .out_valid(m_axis_tvalid),
    .out_kind (out_kind),
    .out_user (out_user),
    .out_last (m_axis_tlast)
  );

  assign m_axis_tdata = {(DATA_W - USER_W - KIND_W)'(0), out_user, out_kind};

endmodule

// ===== rtl/rraa_ram.sv =====
// generic single write, single read ram with registered read data
module rraa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/rraa_front.sv =====
// input side: accepts transfers, classifies them and queues commands
module rraa_front #(
  parameter int MAX_USERS = rraa_pkg::MAX_USERS_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic [rraa_pkg::size_w(MAX_USERS)-1:0]     ring_n,
  input  logic                                       s_axis_tvalid,
  output logic                                       s_axis_tready,
  input  logic [rraa_pkg::DATA_W-1:0]                s_axis_tdata,
  output rraa_pkg::cmd_t                             cmd,
  output logic                                       cmd_valid,
  input  logic                                       cmd_pop
);
  import rraa_pkg::*;

  localparam int SZ_W = size_w(MAX_USERS);

  cmd_t              q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] cnt;
  cmd_t              cls_cmd;
  logic [1:0]        op;
  logic [USER_W-1:0] usr;
  logic              push;

  assign op  = s_axis_tdata[1:0];
  assign usr = s_axis_tdata[USER_W+1:2];

  always_comb begin
    cls_cmd.user = usr;
    unique case (op)
      OP_TICK: cls_cmd.cls = CMD_TICK;
      OP_REQ:  cls_cmd.cls = CMD_REQ;
      OP_REL:  cls_cmd.cls = CMD_REL;
      default: cls_cmd.cls = CMD_ERR;
    endcase
    if (cls_cmd.cls != CMD_TICK && SZ_W'(usr) >= ring_n) begin
      cls_cmd.cls = CMD_ERR;
    end
  end

  assign s_axis_tready = (cnt != QCNT_W'(QDEPTH));
  assign push          = s_axis_tvalid && s_axis_tready;
  assign cmd_valid     = (cnt != '0);
  assign cmd           = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (cmd_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !cmd_pop) begin
        cnt <= cnt + 1'b1;
      end else if (!push && cmd_pop) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= cls_cmd;
    end
  end

endmodule

// ===== rtl/rraa_back.sv =====
// execution side: user states, stamp memory, neighbour tests and result register
module rraa_back #(
  parameter int MAX_USERS = rraa_pkg::MAX_USERS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic [rraa_pkg::size_w(MAX_USERS)-1:0] ring_n,
  input  rraa_pkg::cmd_t                         cmd,
  input  logic                                   cmd_valid,
  output logic                                   cmd_pop,
  input  logic                                   out_ready,
  output logic                                   out_valid,
  output rraa_pkg::kind_t                        out_kind,
  output logic [rraa_pkg::USER_W-1:0]            out_user,
  output logic                                   out_last
);
  import rraa_pkg::*;

  localparam int SZ_W  = size_w(MAX_USERS);
  localparam int IDX_W = idx_w(MAX_USERS);

  back_state_t          state;
  back_state_t          state_next;
  logic [TIME_W-1:0]    t;
  logic [MAX_USERS-1:0] hungry;
  logic [MAX_USERS-1:0] eating;
  logic [MAX_USERS-1:0] svalid;
  cmd_t                 cur;
  logic [IDX_W-1:0]     cand;
  logic [IDX_W-1:0]     nb_l;
  logic [IDX_W-1:0]     nb_r;
  logic                 pass;
  logic [1:0]           step;
  logic                 rd_vld;
  logic [TIME_W-1:0]    rd_data;
  logic [TIME_W-1:0]    age_l;
  logic [TIME_W-1:0]    age_c;
  logic [TIME_W-1:0]    age_r;
  logic                 gl;
  logic                 gr;

  logic [IDX_W-1:0]     u_idx;
  logic [IDX_W-1:0]     cand_l;
  logic [IDX_W-1:0]     cand_r;
  logic [IDX_W-1:0]     rd_addr;
  logic [TIME_W-1:0]    rd_age;
  logic                 out_free;
  logic                 grant;
  logic                 do_tick;
  logic                 do_req;
  logic                 do_rel;
  logic                 do_eval;
  logic                 emit;
  kind_t                e_kind;
  logic [USER_W-1:0]    e_user;
  logic                 e_last;

  function automatic logic [IDX_W-1:0] left_of(input logic [IDX_W-1:0] x,
                                               input logic [SZ_W-1:0]  n);
    return (x == '0) ? IDX_W'(n - 1'b1) : x - 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] right_of(input logic [IDX_W-1:0] x,
                                                input logic [SZ_W-1:0]  n);
    return ((SZ_W'(x) + 1'b1) >= n) ? '0 : x + 1'b1;
  endfunction

  assign u_idx    = IDX_W'(cmd.user);
  assign cand_l   = left_of(cand, ring_n);
  assign cand_r   = right_of(cand, ring_n);
  assign out_free = !out_valid || out_ready;
  assign rd_age   = t - (rd_vld ? rd_data : '0);
  assign grant    = hungry[cand] && !eating[cand_l] && !eating[cand_r] &&
                    (age_c >= age_l) && (age_c >= age_r);

  always_comb begin
    case (step)
      2'd0:    rd_addr = cand_l;
      2'd1:    rd_addr = cand;
      default: rd_addr = cand_r;
    endcase
  end

  rraa_ram #(
    .WIDTH(TIME_W),
    .DEPTH(MAX_USERS)
  ) u_stamp_ram (
    .clk  (clk),
    .we   (do_rel),
    .waddr(u_idx),
    .wdata(t),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  always_comb begin
    state_next = state;
    cmd_pop    = 1'b0;
    do_tick    = 1'b0;
    do_req     = 1'b0;
    do_rel     = 1'b0;
    do_eval    = 1'b0;
    emit       = 1'b0;
    e_kind     = KIND_NONE;
    e_user     = cmd.user;
    e_last     = 1'b1;
    unique case (state)
      B_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_pop = 1'b1;
          unique case (cmd.cls)
            CMD_TICK: begin
              do_tick = 1'b1;
              emit    = 1'b1;
              e_user  = '0;
            end
            CMD_REQ: begin
              if (!hungry[u_idx] && !eating[u_idx]) begin
                do_req     = 1'b1;
                state_next = B_READ;
              end else begin
                emit   = 1'b1;
                e_kind = KIND_ERROR;
              end
            end
            CMD_REL: begin
              if (eating[u_idx]) begin
                do_rel     = 1'b1;
                state_next = B_READ;
              end else begin
                emit   = 1'b1;
                e_kind = KIND_ERROR;
              end
            end
            default: begin
              emit   = 1'b1;
              e_kind = KIND_ERROR;
            end
          endcase
        end
      end
      B_READ: begin
        if (step == 2'd3) begin
          state_next = B_EVAL;
        end
      end
      B_EVAL: begin
        do_eval    = 1'b1;
        state_next = (cur.cls == CMD_REL && !pass) ? B_READ : B_EMIT;
      end
      B_EMIT: begin
        if (out_free) begin
          emit       = 1'b1;
          state_next = B_IDLE;
          e_user     = cur.user;
          if (cur.cls == CMD_REQ) begin
            e_kind = gl ? KIND_GRANT : KIND_NONE;
          end else if (gl) begin
            e_kind = KIND_GRANT;
            e_user = USER_W'(nb_l);
            if (gr) begin
              e_last     = 1'b0;
              state_next = B_EMIT2;
            end
          end else if (gr) begin
            e_kind = KIND_GRANT;
            e_user = USER_W'(nb_r);
          end
        end
      end
      B_EMIT2: begin
        if (out_free) begin
          emit       = 1'b1;
          e_kind     = KIND_GRANT;
          e_user     = USER_W'(nb_r);
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      t         <= '0;
      hungry    <= '0;
      eating    <= '0;
      svalid    <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (do_tick) begin
        t <= t + 1'b1;
      end
      if (do_req) begin
        hungry[u_idx] <= 1'b1;
      end
      if (do_rel) begin
        eating[u_idx] <= 1'b0;
        svalid[u_idx] <= 1'b1;
      end
      if (do_eval && grant) begin
        hungry[cand] <= 1'b0;
        eating[cand] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_vld <= svalid[rd_addr];
    if (cmd_pop) begin
      cur <= cmd;
    end
    if (state_next == B_READ && state != B_READ) begin
      step <= 2'd0;
    end else if (state == B_READ) begin
      step <= step + 1'b1;
    end
    if (state == B_READ) begin
      case (step)
        2'd1:    age_l <= rd_age;
        2'd2:    age_c <= rd_age;
        2'd3:    age_r <= rd_age;
        default: age_l <= age_l;
      endcase
    end
    if (do_req) begin
      cand <= u_idx;
      pass <= 1'b0;
    end
    if (do_rel) begin
      cand <= left_of(u_idx, ring_n);
      nb_l <= left_of(u_idx, ring_n);
      nb_r <= right_of(u_idx, ring_n);
      pass <= 1'b0;
    end
    if (do_eval) begin
      if (!pass) begin
        gl   <= grant;
        cand <= nb_r;
        pass <= 1'b1;
      end else begin
        gr <= grant;
      end
    end
    if (emit) begin
      out_kind <= e_kind;
      out_user <= e_user;
      out_last <= e_last;
    end
  end

endmodule

// ===== rtl/rraa_checker.sv =====
// port-level checks for the ring resource age arbiter, bound to the top level
module rraa_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [rraa_pkg::DATA_W-1:0] m_axis_tdata,
  input logic                        m_axis_tlast
);
  import rraa_pkg::*;

  a_reset_clears_out: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  a_error_is_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[1:0] == KIND_ERROR |-> m_axis_tlast)
    else $error("error result not last");

  a_first_of_two_is_grant: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[1:0] == KIND_GRANT)
    else $error("non-last result is not a grant");

  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3 && m_axis_tdata[7:5] == 3'd0)
    else $error("illegal result encoding");

endmodule

bind ring_resource_age_arbiter_unit rraa_checker u_rraa_checker (
  .clk          (clk),
  .rst          (rst),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tlast (m_axis_tlast)
);
